FILE: hw/rtl/ltkc_pkg.sv
// Shared types and constants for the LRU timestamp key cache.
package ltkc_pkg;

   localparam int unsigned LTKC_ENTRIES = 256;
   localparam int unsigned KEY_W        = 32;
   localparam int unsigned VAL_W        = 32;
   localparam int unsigned STAMP_W      = 32;

   typedef struct packed {
      logic [KEY_W-1:0]   lookup_key;
      logic [STAMP_W-1:0] frame_stamp;
      logic [VAL_W-1:0]   fill_value;
      logic               fill_ok;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] result_value;
      logic             was_hit;
      logic             victim_valid;
      logic [VAL_W-1:0] victim_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

FILE: hw/rtl/lru_timestamp_key_cache_core.sv
// Top level of the LRU timestamp key cache: scan engine over one entry memory.
//
//  channel   ports                         handshake
//  -------   ---------------------------   ---------------------------------------
//  request   start, busy, req_data         word taken at edge with start & !busy
//  response  rsp_strobe, rsp_data          word shown for one cycle, always taken
//
// Scan: a lookup walks the filled slots one per cycle through the entry
// memory's single read port; a miss reads every filled slot, while a hit
// stops further reads, and any read past the hit that is already in flight
// has to drain before the response.
// busy drops in the strobe cycle, so a new word can be taken right then.
// Reset: state machine and fill count clear; memory contents are left as is,
// only slots below the fill count are ever read.
// The receiver cannot stall; the response register is loaded once per word.
module lru_timestamp_key_cache_core
   import ltkc_pkg::*;
#(
   parameter int unsigned ENTRIES = LTKC_ENTRIES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int unsigned AW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   // one memory word per slot: key, value and recency stamp together
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   entry_type mem [ENTRIES];

   state_type state_ff, state_in;

   req_type          req_ff, req_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic [CW-1:0]    issue_ff, issue_in;     // next slot to read
   logic             rd_vld_ff, rd_vld_in;   // read data valid this cycle
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;   // slot of the read data
   entry_type        rd_data_ff;
   logic             hit_ff, hit_in;
   logic [AW-1:0]    hit_idx_ff, hit_idx_in;
   logic [VAL_W-1:0] hit_val_ff, hit_val_in;
   logic [STAMP_W-1:0] min_stamp_ff, min_stamp_in;
   logic [AW-1:0]    min_idx_ff, min_idx_in;
   logic [VAL_W-1:0] min_val_ff, min_val_in;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;

   logic             accept;
   logic             rd_en;
   logic             scan_done;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   entry_type        mem_wdata;
   logic             usable_fill;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   assign accept      = start && !busy;
   assign usable_fill = req_ff.fill_ok && (req_ff.fill_value != '0);

   // issue reads in order until a hit shows up or all filled slots are read
   assign rd_en     = (state_ff == ST_SCAN) && !hit_ff && (issue_ff < fill_ff);
   assign scan_done = !rd_vld_ff && (hit_ff || (issue_ff >= fill_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in       = req_ff;
      fill_in      = fill_ff;
      issue_in     = issue_ff;
      rd_vld_in    = rd_en;
      rd_idx_in    = issue_ff[AW-1:0];
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_val_in   = hit_val_ff;
      min_stamp_in = min_stamp_ff;
      min_idx_in   = min_idx_ff;
      min_val_in   = min_val_ff;
      rsp_in       = rsp_ff;
      strobe_in    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = hit_idx_ff;
      mem_wdata    = '{key: req_ff.lookup_key, value: hit_val_ff,
                       stamp: req_ff.frame_stamp};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               issue_in     = '0;
               hit_in       = 1'b0;
               min_stamp_in = '1;
               min_idx_in   = '0;
            end
         end
         ST_SCAN: begin
            if (rd_en) issue_in = issue_ff + CW'(1);
            // compare the word read last cycle; lowest matching slot wins
            if (rd_vld_ff && !hit_ff) begin
               if (rd_data_ff.key == req_ff.lookup_key) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_val_in = rd_data_ff.value;
               end
               // slot 0 seeds the minimum so an all-max table still picks it
               if ((rd_data_ff.stamp < min_stamp_ff) || (rd_idx_ff == '0)) begin
                  min_stamp_in = rd_data_ff.stamp;
                  min_idx_in   = rd_idx_ff;
                  min_val_in   = rd_data_ff.value;
               end
            end
         end
         ST_FINISH: begin
            strobe_in = 1'b1;
            rsp_in    = '0;
            if (hit_ff) begin
               // restamp the hit slot
               mem_we              = 1'b1;
               rsp_in.result_value = hit_val_ff;
               rsp_in.was_hit      = 1'b1;
            end else if (usable_fill) begin
               mem_we              = 1'b1;
               mem_wdata.value     = req_ff.fill_value;
               rsp_in.result_value = req_ff.fill_value;
               if (fill_ff == FULL_COUNT) begin
                  mem_waddr           = min_idx_ff;
                  rsp_in.victim_valid = 1'b1;
                  rsp_in.victim_value = min_val_ff;
               end else begin
                  mem_waddr = fill_ff[AW-1:0];
                  fill_in   = fill_ff + CW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // entry memory: one write port, one registered read port; the single write
   // lands after the scan, so reads and writes never overlap
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (rd_en) rd_data_ff <= mem[issue_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         rd_vld_ff <= rd_vld_in;
         hit_ff    <= hit_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      issue_ff     <= issue_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_val_ff   <= hit_val_in;
      min_stamp_ff <= min_stamp_in;
      min_idx_ff   <= min_idx_in;
      min_val_ff   <= min_val_in;
      rsp_ff       <= rsp_in;
   end

endmodule

FILE: hw/rtl/ltkc_checker.sv
// Port-level checker for the LRU timestamp key cache, bound to the top level.
module ltkc_checker
   import ltkc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // an accepted word keeps the block busy for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // the response comes as busy falls, one per word
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("response strobe outside the end of a lookup");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two response strobes in a row");

   // a hit never evicts
   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.was_hit) |-> !rsp_data.victim_valid)
      else $error("eviction reported on a hit");

   // an eviction only happens for a usable, nonzero fill
   a_victim_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.victim_valid) |-> (rsp_data.result_value != '0))
      else $error("eviction without a nonzero fill");

endmodule

bind lru_timestamp_key_cache_core ltkc_checker u_ltkc_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the LRU timestamp key cache core.
module testbench
   import ltkc_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int          RANDOM_LOOKUPS  = 440;
   // last stretch of the random part runs back to back, no start gaps
   localparam int          NO_IDLE_TAIL    = 60;
   localparam int          DIRECTED_ROWS   = 17;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   lru_timestamp_key_cache_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Cache predictor: its own copy of the slot contents and fill level.
   // Slots at or above slots_used are never read, matching the block.
   // ---------------------------------------------------------------------
   logic [KEY_W-1:0]   slot_key   [LTKC_ENTRIES];
   logic [VAL_W-1:0]   slot_value [LTKC_ENTRIES];
   logic [STAMP_W-1:0] slot_stamp [LTKC_ENTRIES];
   int unsigned        slots_used = 0;

   // Expected response words, oldest first.
   rsp_type            expected_lookups [$];
   // Keys that went into the cache at some point; they may since be evicted.
   logic [KEY_W-1:0]   known_keys [$];
   int unsigned        mismatches  = 0;
   int unsigned        cycle_count = 0;
   bit                 idle_on     = 1'b1;

   function automatic rsp_type cache_lookup(input req_type w);
      rsp_type            r;
      int unsigned        slot;
      logic [STAMP_W-1:0] oldest_stamp;
      r = '0;
      // hit: lowest matching slot wins, its stamp moves to this frame
      for (int i = 0; i < slots_used; i++) begin
         if (slot_key[i] == w.lookup_key) begin
            slot_stamp[i]  = w.frame_stamp;
            r.result_value = slot_value[i];
            r.was_hit      = 1'b1;
            return r;
         end
      end
      // a zero handle counts as a failed fill even with fill_ok set
      if (!w.fill_ok || w.fill_value == '0)
         return r;
      if (slots_used >= LTKC_ENTRIES) begin
         // full: smallest stamp goes, plain unsigned compare, ties to lowest slot
         slot         = 0;
         oldest_stamp = '1;
         for (int i = 0; i < slots_used; i++) begin
            if (slot_stamp[i] < oldest_stamp) begin
               oldest_stamp = slot_stamp[i];
               slot         = i;
            end
         end
         r.victim_valid = 1'b1;
         r.victim_value = slot_value[slot];
      end else begin
         slot       = slots_used;
         slots_used = slots_used + 1;
      end
      slot_key[slot]   = w.lookup_key;
      slot_value[slot] = w.fill_value;
      slot_stamp[slot] = w.frame_stamp;
      r.result_value   = w.fill_value;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table. Rows with typed set carry a hand-written response;
   // the rest take the predictor's answer.
   // ---------------------------------------------------------------------
   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   directed_row_type plan [DIRECTED_ROWS] = '{
      // miss with fill_ok but zero handle: nothing stored
      '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b1,
        '{32'h0, 1'b0, 1'b0, 32'h0}},
      // miss with failed fill
      '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0005, 1'b0}, 1'b1,
        '{32'h0, 1'b0, 1'b0, 32'h0}},
      '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
        '{32'h0, 1'b0, 1'b0, 32'h0}},
      // first real fill goes to a free slot, no victim
      '{'{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0}},
      // hit ignores the offered fill
      '{'{32'h0000_0000, 32'h0000_0001, 32'h0000_0007, 1'b1}, 1'b1,
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0}},
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1}, 1'b1,
        '{32'h0000_0001, 1'b0, 1'b0, 32'h0}},
      // hit with a failed fill still returns the stored value
      '{'{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
        '{32'h0000_0001, 1'b1, 1'b0, 32'h0}},
      '{'{32'h1234_5678, 32'h0000_0002, 32'h0000_ABCD, 1'b0}, 1'b1,
        '{32'h0, 1'b0, 1'b0, 32'h0}},
      '{'{32'hA5A5_A5A5, 32'h8000_0000, 32'h5A5A_5A5A, 1'b1}, 1'b0, '0},
      '{'{32'h5A5A_5A5A, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 1'b1}, 1'b0, '0},
      '{'{32'hA5A5_A5A5, 32'h0000_0003, 32'h0000_0000, 1'b0}, 1'b0, '0},
      '{'{32'h1234_5678, 32'h0000_0003, 32'h0000_ABCD, 1'b1}, 1'b0, '0},
      '{'{32'h1234_5678, 32'h0000_0004, 32'hFFFF_FFFE, 1'b1}, 1'b0, '0},
      '{'{32'h0000_0001, 32'h0000_0004, 32'h8000_0000, 1'b1}, 1'b0, '0},
      '{'{32'h8000_0000, 32'h0000_0004, 32'h0000_0001, 1'b1}, 1'b0, '0},
      '{'{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1}, 1'b0, '0},
      '{'{32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0}
   };

   // ---------------------------------------------------------------------
   // Request side. Called right after a posedge (or reset release); drives
   // on falling edges and returns at the posedge that took the word.
   // Gaps land both before a word and while the block is mid-scan.
   // ---------------------------------------------------------------------
   task automatic drive_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type got;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_data <= w;
      start    <= 1'b1;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
         @(negedge clock);
         if (idle_on && $urandom_range(0, 11) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            start <= 1'b1;
         end
      end
      // word taken at this edge: predict in acceptance order
      got = cache_lookup(w);
      expected_lookups.push_back(typed ? want : got);
      if (!got.was_hit && got.result_value != '0)
         known_keys.push_back(w.lookup_key);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      req_type          w;
      logic [STAMP_W-1:0] frame_now;
      int unsigned      pick;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      frame_now = 32'd16;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         drive_word(plan[i].word, plan[i].typed, plan[i].want);

      // Random lookups. Until the cache is full most keys are fresh so the
      // fill level climbs to the top; after that half the traffic reuses
      // old keys (hits, or misses on evicted ones) and fresh keys evict.
      for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
         idle_on = (n < RANDOM_LOOKUPS - NO_IDLE_TAIL);

         pick = $urandom_range(0, 99);
         if (known_keys.size() == 0 || pick < ((slots_used >= LTKC_ENTRIES) ? 50 : 90))
            w.lookup_key = $urandom;
         else if (pick < 97)
            w.lookup_key = known_keys[$urandom_range(0, known_keys.size() - 1)];
         else
            w.lookup_key = (pick == 98) ? '1 : '0;

         // mostly rising frames, many repeats (stamp ties), some out of order
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               frame_now     = frame_now + $urandom_range(1, 3);
               w.frame_stamp = frame_now;
            end
            5, 6, 7: begin
               w.frame_stamp = frame_now;
            end
            8: begin
               w.frame_stamp = $urandom;
            end
            default: begin
               w.frame_stamp = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                                    : 32'($urandom_range(0, 3));
            end
         endcase

         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            w.fill_ok    = 1'b1;
            w.fill_value = $urandom;
         end else if (pick < 92) begin
            w.fill_ok    = 1'b1;
            w.fill_value = '0;
         end else begin
            w.fill_ok    = 1'b0;
            w.fill_value = $urandom;
         end

         drive_word(w, 1'b0, '0);
      end

      @(negedge clock);
      start <= 1'b0;
      while (expected_lookups.size() != 0)
         @(posedge clock);
      // a stray extra strobe would show within one full scan
      repeat (LTKC_ENTRIES + 8) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: every strobe cycle is a word, taken at its closing edge.
   // ---------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_lookups.size() == 0) begin
            $display("%0t: response word expected none actual %h", $realtime, rsp_data);
            mismatches++;
         end else begin
            want = expected_lookups.pop_front();
            compare_field("result_value", want.result_value, rsp_data.result_value);
            compare_field("was_hit", 32'(want.was_hit), 32'(rsp_data.was_hit));
            compare_field("victim_valid", 32'(want.victim_valid), 32'(rsp_data.victim_valid));
            compare_field("victim_value", want.victim_value, rsp_data.victim_value);
         end
      end
   end

   // Watchdog: far beyond a full-scan-per-word run with every gap taken.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule

FILE: sim.f
hw/rtl/ltkc_pkg.sv
hw/rtl/lru_timestamp_key_cache_core.sv
hw/rtl/ltkc_checker.sv
tb/testbench.sv
